FILE: rtl/prq_pkg.sv
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and constants of the priority ready queue: entry layout,
// operation and status codes, and the derived widths of the slot store.
// ----------------------------------------------------------------------------
package prq_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int OCC_W  = 5;
    localparam int ID_W   = 10;
    localparam int PRIO_W = 8;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    typedef logic [OP_W-1:0] t_op;
    typedef logic [ST_W-1:0] t_status;

    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_REMOVE = 2'd1;
    localparam t_op OP_SELECT = 2'd2;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_EMPTY     = 2'd1;
    localparam t_status ST_FULL      = 2'd2;
    localparam t_status ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

endpackage

FILE: rtl/prq_if.sv
// ----------------------------------------------------------------------------
// prq_cmd_if / prq_res_if
// Valid/ready channels of the priority ready queue: commands in, results out.
// ----------------------------------------------------------------------------
interface prq_cmd_if
    import prq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   process_id;
    logic [PRIO_W-1:0] priority_req;

    modport source (output valid, output op, output process_id, output priority_req,
                    input ready);
    modport sink   (input valid, input op, input process_id, input priority_req,
                    output ready);
endinterface

interface prq_res_if
    import prq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [ID_W-1:0]   chosen_id;
    logic [PRIO_W-1:0] chosen_priority;
    logic [OCC_W-1:0]  occupancy;

    modport source (output valid, output status, output chosen_id,
                    output chosen_priority, output occupancy, input ready);
    modport sink   (input valid, input status, input chosen_id,
                    input chosen_priority, input occupancy, output ready);
endinterface

FILE: rtl/prq_ram.sv
// ----------------------------------------------------------------------------
// prq_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module prq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/priority_ready_queue.sv
// ----------------------------------------------------------------------------
// priority_ready_queue
// Ready queue for highest-priority-first scheduling, slots kept in arrival
// order in a single RAM.
// ----------------------------------------------------------------------------
// One command is in work at a time. Insert, the unused op code, and remove or
// select on an empty queue go straight to the result state, which loads the
// result register once the output register is free. Remove and select on a
// non-empty queue first walk the occupied slots through the RAM read port,
// one slot per cycle, and then load the result register the same way: a
// remove compacts the later slots down as it goes, a select tracks the
// smallest priority (earliest on ties). The queue is ready for the next
// command in the cycle after the result is registered, so a command is
// never accepted while another is in work. A finished result waits in the
// output register while the next command is accepted; the result of that
// command waits until the first is taken, and the input stalls meanwhile.
// ----------------------------------------------------------------------------
module priority_ready_queue
    import prq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    prq_cmd_if.sink   i_cmd,
    prq_res_if.source o_res
);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_found, n_found;
    t_op                 r_op;
    logic [ID_W-1:0]     r_pid;
    logic [PRIO_W-1:0]   r_prio;
    t_entry              r_best, n_best;

    logic                r_out_vld, n_out_vld;
    t_status             r_out_status, n_out_status;
    logic [ID_W-1:0]     r_out_id, n_out_id;
    logic [PRIO_W-1:0]   r_out_prio, n_out_prio;
    logic [OCC_W-1:0]    r_out_occ, n_out_occ;

    logic                accept;
    logic                out_free;
    logic                last;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    t_entry              wr_data;
    t_entry              rd_data;

    prq_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign i_cmd.ready = (r_state == S_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign out_free    = !r_out_vld || o_res.ready;
    assign last        = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if ((i_cmd.op inside {OP_REMOVE, OP_SELECT}) && r_count != '0) begin
                        n_state = S_WALK;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_WALK: begin
                if (last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count      = r_count;
        n_idx        = r_idx;
        n_found      = r_found;
        n_best       = r_best;
        n_out_vld    = r_out_vld && !o_res.ready;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        n_out_prio   = r_out_prio;
        n_out_occ    = r_out_occ;
        rd_en        = 1'b0;
        rd_addr      = r_idx + IDX_W'(1);
        wr_en        = 1'b0;
        wr_addr      = r_idx - IDX_W'(1);
        wr_data      = rd_data;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    rd_en   = 1'b1;
                    rd_addr = '0;
                    n_idx   = '0;
                    n_found = 1'b0;
                end
            end
            S_WALK: begin
                rd_en = !last;
                n_idx = r_idx + IDX_W'(1);
                if (r_idx == '0 || rd_data.prio < r_best.prio) begin
                    n_best = rd_data;
                end
                // compact later slots down once the match has been passed
                if (r_found) begin
                    wr_en = 1'b1;
                end else if (r_op == OP_REMOVE && rd_data.id == r_pid) begin
                    n_found = 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_status = ST_OK;
                    n_out_id     = '0;
                    n_out_prio   = '0;
                    case (r_op)
                        OP_INSERT: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_out_status = ST_FULL;
                            end else begin
                                wr_en        = 1'b1;
                                wr_addr      = r_count[IDX_W-1:0];
                                wr_data.id   = r_pid;
                                wr_data.prio = r_prio;
                                n_count      = r_count + CNT_W'(1);
                            end
                        end
                        OP_REMOVE: begin
                            if (r_found) begin
                                n_count = r_count - CNT_W'(1);
                            end else begin
                                n_out_status = ST_NOT_FOUND;
                            end
                        end
                        OP_SELECT: begin
                            if (r_count == '0) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_out_id   = r_best.id;
                                n_out_prio = r_best.prio;
                            end
                        end
                        default: n_out_status = ST_OK;
                    endcase
                    n_out_occ = OCC_W'(n_count);
                end
            end
            default: n_idx = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
            r_found   <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_cmd.op;
            r_pid  <= i_cmd.process_id;
            r_prio <= i_cmd.priority_req;
        end
        r_idx        <= n_idx;
        r_best       <= n_best;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
        r_out_prio   <= n_out_prio;
        r_out_occ    <= n_out_occ;
    end

    assign o_res.valid           = r_out_vld;
    assign o_res.status          = r_out_status;
    assign o_res.chosen_id       = r_out_id;
    assign o_res.chosen_priority = r_out_prio;
    assign o_res.occupancy       = r_out_occ;

endmodule

FILE: tb/tb_priority_ready_queue.sv
// ----------------------------------------------------------------------------
// tb_priority_ready_queue
// Self-checking bench for the priority ready queue. A short table of
// directed commands covers the empty, full and not-found corners, ties and
// duplicate ids. Phases of random commands follow, leaning toward filling,
// draining or selecting. Results are checked in order, typed rows against
// their table entry and all others against a queue-based predictor. Commands
// come in bursts with gaps, and results stall on a rotating pattern.
// ----------------------------------------------------------------------------
module tb_priority_ready_queue;
    import prq_pkg::*;

    localparam t_op OP_UNUSED    = 2'd3;
    localparam int  RANDOM_ITEMS = 1400;
    localparam int  DRAIN_CYCLES = 40;
    localparam int  MAX_REPORTS  = 10;
    localparam int  N_ROWS       = 15;
    localparam int  INSERT_CUT [4] = '{65, 20, 40, 25};
    localparam int  REMOVE_CUT [4] = '{80, 75, 70, 40};
    localparam int  SELECT_CUT     = 97;

    typedef struct packed {
        t_status           status;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [OCC_W-1:0]  occ;
    } t_result;

    typedef struct packed {
        t_op               op;
        logic [ID_W-1:0]   pid;
        logic [PRIO_W-1:0] prio;
        logic [4:0]        reps;
        logic              typed;
        t_result           res;
    } t_row;

    localparam t_row DIRECTED_ROWS [N_ROWS] = '{
        '{OP_SELECT, 10'd0,     8'd0,    5'd1,  1'b1, '{ST_EMPTY,     10'd0, 8'd0, 5'd0}},
        '{OP_REMOVE, 10'd5,     8'd0,    5'd1,  1'b1, '{ST_NOT_FOUND, 10'd0, 8'd0, 5'd0}},
        '{OP_UNUSED, 10'h3FF,   8'hFF,   5'd1,  1'b1, '{ST_OK,        10'd0, 8'd0, 5'd0}},
        '{OP_INSERT, 10'h3FF,   8'hFF,   5'd1,  1'b1, '{ST_OK,        10'd0, 8'd0, 5'd1}},
        '{OP_INSERT, 10'd0,     8'd0,    5'd1,  1'b1, '{ST_OK,        10'd0, 8'd0, 5'd2}},
        '{OP_SELECT, 10'd0,     8'd0,    5'd1,  1'b1, '{ST_OK,        10'd0, 8'd0, 5'd2}},
        '{OP_INSERT, 10'h155,   8'd0,    5'd1,  1'b0, '0},
        '{OP_SELECT, 10'h2AA,   8'h55,   5'd1,  1'b0, '0},
        '{OP_INSERT, 10'h3FF,   8'd7,    5'd1,  1'b0, '0},
        '{OP_REMOVE, 10'h3FF,   8'd0,    5'd1,  1'b0, '0},
        '{OP_INSERT, 10'h2AA,   8'hAA,   5'd13, 1'b0, '0},
        '{OP_INSERT, 10'd1,     8'd1,    5'd1,  1'b1, '{ST_FULL,      10'd0, 8'd0, 5'd16}},
        '{OP_SELECT, 10'd0,     8'd0,    5'd1,  1'b0, '0},
        '{OP_REMOVE, 10'h2AA,   8'd0,    5'd1,  1'b0, '0},
        '{OP_REMOVE, 10'h3FE,   8'd0,    5'd1,  1'b1, '{ST_NOT_FOUND, 10'd0, 8'd0, 5'd15}}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    prq_cmd_if cmd_if ();
    prq_res_if res_if ();

    priority_ready_queue u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    always #5 i_clk = ~i_clk;

    t_entry      ready_list[$];
    t_result     pending_results[$];
    int          fail_count      = 0;
    int          results_checked = 0;
    int          items_sent      = 0;
    int          full_hits       = 0;
    int          empty_selects   = 0;
    int          remove_misses   = 0;
    int          peak_occupancy  = 0;
    int          burst_left      = 1;
    int          max_gap         = 3;
    logic [15:0] stall_pat       = 16'hFFFF;
    int          stall_pos       = 0;

    function automatic t_result queue_step(t_op op, logic [ID_W-1:0] pid,
                                           logic [PRIO_W-1:0] prio);
        t_result r;
        int      hit;
        int      best;
        int      i;
        r    = '0;
        hit  = -1;
        best = 0;
        case (op)
            OP_INSERT: begin
                if (ready_list.size() >= DEPTH) begin
                    r.status = ST_FULL;
                    full_hits++;
                end else begin
                    ready_list.push_back(t_entry'{id: pid, prio: prio});
                end
            end
            OP_REMOVE: begin
                for (i = 0; i < ready_list.size(); i++)
                    if (hit < 0 && ready_list[i].id == pid) hit = i;
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                    remove_misses++;
                end else begin
                    ready_list.delete(hit);
                end
            end
            OP_SELECT: begin
                if (ready_list.size() == 0) begin
                    r.status = ST_EMPTY;
                    empty_selects++;
                end else begin
                    for (i = 1; i < ready_list.size(); i++)
                        if (ready_list[i].prio < ready_list[best].prio) best = i;
                    r.id   = ready_list[best].id;
                    r.prio = ready_list[best].prio;
                end
            end
            default: ;
        endcase
        r.occ = OCC_W'(ready_list.size());
        if (ready_list.size() > peak_occupancy) peak_occupancy = ready_list.size();
        return r;
    endfunction

    function automatic void report_failure(string what, t_result want, t_result got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t %s: expected st=%0d id=%0d prio=%0d occ=%0d, got st=%0d id=%0d prio=%0d occ=%0d",
                     $time, what, want.status, want.id, want.prio, want.occ,
                     got.status, got.id, got.prio, got.occ);
    endfunction

    // called at a falling edge; returns at a falling edge
    task automatic send_cmd(t_op op, logic [ID_W-1:0] pid, logic [PRIO_W-1:0] prio,
                            logic typed, t_result typed_res);
        t_result predicted;
        cmd_if.valid        <= 1'b1;
        cmd_if.op           <= op;
        cmd_if.process_id   <= pid;
        cmd_if.priority_req <= prio;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        predicted = queue_step(op, pid, prio);
        pending_results.push_back(typed ? typed_res : predicted);
        items_sent++;
        @(negedge i_clk);
        if (max_gap > 0) begin
            burst_left--;
            if (burst_left <= 0) begin
                cmd_if.valid <= 1'b0;
                repeat ($urandom_range(1, max_gap)) @(negedge i_clk);
                burst_left = $urandom_range(1, 20);
            end
        end
    endtask

    always @(negedge i_clk) begin
        stall_pos = (stall_pos + 1) % 16;
        if (stall_pos == 0)
            stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        res_if.ready <= stall_pat[stall_pos];
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = {res_if.status, res_if.chosen_id, res_if.chosen_priority, res_if.occupancy};
            if (pending_results.size() == 0) begin
                report_failure("unexpected transaction", '0, got);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.status !== want.status || got.id !== want.id ||
                    got.prio !== want.prio || got.occ !== want.occ)
                    report_failure("mismatch", want, got);
            end
        end
    end

    initial begin
        #6000000;
        $display("timeout with %0d transactions outstanding", pending_results.size());
        $display("** priority_ready_queue: FAILED **");
        $finish;
    end

    initial begin
        int                row;
        int                rep;
        int                n;
        int                mode;
        int                roll;
        t_op               op;
        logic [ID_W-1:0]   pid;
        logic [PRIO_W-1:0] prio;
        cmd_if.valid        = 1'b0;
        cmd_if.op           = OP_INSERT;
        cmd_if.process_id   = '0;
        cmd_if.priority_req = '0;
        res_if.ready        = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        burst_left = $urandom_range(1, 20);
        for (row = 0; row < N_ROWS; row++)
            for (rep = 0; rep < DIRECTED_ROWS[row].reps; rep++)
                send_cmd(DIRECTED_ROWS[row].op, DIRECTED_ROWS[row].pid,
                         DIRECTED_ROWS[row].prio, DIRECTED_ROWS[row].typed,
                         DIRECTED_ROWS[row].res);

        n = 0;
        while (n < RANDOM_ITEMS) begin
            mode       = $urandom_range(0, 3);
            max_gap    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 20);
            repeat ($urandom_range(20, 80)) begin
                roll = $urandom_range(0, 99);
                if (roll < INSERT_CUT[mode])      op = OP_INSERT;
                else if (roll < REMOVE_CUT[mode]) op = OP_REMOVE;
                else if (roll < SELECT_CUT)       op = OP_SELECT;
                else                              op = OP_UNUSED;
                // removes mostly hit a held id; some inserts duplicate one
                if ((op == OP_REMOVE || op == OP_INSERT) && ready_list.size() != 0 &&
                    $urandom_range(0, 99) < ((op == OP_REMOVE) ? 80 : 25))
                    pid = ready_list[$urandom_range(0, ready_list.size() - 1)].id;
                else
                    pid = ID_W'($urandom_range(0, 1023));
                prio = ($urandom_range(0, 1) == 0) ? PRIO_W'($urandom_range(0, 3))
                                                   : PRIO_W'($urandom_range(0, 255));
                send_cmd(op, pid, prio, 1'b0, '0);
                n++;
            end
        end
        cmd_if.valid <= 1'b0;

        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_results.size() != 0) fail_count++;

        $display("commands sent %0d, results checked %0d, peak occupancy %0d",
                 items_sent, results_checked, peak_occupancy);
        $display("inserts on full %0d, selects on empty %0d, removes not found %0d",
                 full_hits, empty_selects, remove_misses);
        if (fail_count == 0) begin
            $display("** priority_ready_queue: PASSED **");
        end else begin
            $display("failures: %0d", fail_count);
            $display("** priority_ready_queue: FAILED **");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/prq_pkg.sv
rtl/prq_if.sv
rtl/prq_ram.sv
rtl/priority_ready_queue.sv
tb/tb_priority_ready_queue.sv
